>>> design/cts_pkg.sv
package cts_pkg;

    // default cap on the point count of a move
    localparam int MAX_POINTS_DEF = 100;

    // register reset values
    localparam logic [9:0]  STEP_PERIOD_RST  = 10'd50;
    localparam logic [15:0] MAX_DURATION_RST = 16'd5000;

    // register indexes
    localparam logic REG_STEP_PERIOD  = 1'b0;
    localparam logic REG_MAX_DURATION = 1'b1;

    // item kinds carried in s_tuser
    localparam logic ACT_PLAN   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // divider length
    localparam int DIV_STEPS = 32;

    // Q1.16 one
    localparam logic [16:0] S_ONE = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PREP,
        ST_MUL_SS,
        ST_MUL_S3,
        ST_BLEND,
        ST_AX0,
        ST_AX1,
        ST_AX2,
        ST_STORE2,
        ST_OUT
    } st_t;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       prep;
        logic       mul_ss;
        logic       mul_s3;
        logic       blend;
        logic       mul_ax;
        logic [1:0] ax_sel;
        logic       store_ax;
        logic [1:0] st_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

>>> design/cts_div.sv
module cts_div import cts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start_i,
    input  logic [31:0] dividend_i,
    input  logic [15:0] divisor_i,
    output logic [31:0] quot_o,
    output logic        done_o
);

    localparam int CntW = $clog2(DIV_STEPS);

    logic [15:0]     rem_reg,  rem_next;
    logic [31:0]     quot_reg, quot_next;
    logic [CntW-1:0] cnt_reg,  cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [16:0]     shifted;
    logic [16:0]     diff;

    // restoring division, one quotient bit a cycle
    always_comb begin
        shifted   = {rem_reg, quot_reg[31]};
        diff      = shifted - {1'b0, divisor_i};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start_i) begin
            rem_next  = '0;
            quot_next = dividend_i;
            cnt_next  = CntW'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, divisor_i}) begin
                rem_next  = diff[15:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end else begin
                rem_next  = shifted[15:0];
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quot_o = quot_reg;
    assign done_o = done_reg;

endmodule

>>> design/cts_dp.sv
module cts_dp import cts_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic [119:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  cmd_t         cmd_i,
    output sts_t         sts_o,
    input  logic         m_tready,
    output logic         m_tvalid,
    output logic [55:0]  m_tdata,
    output logic [0:0]   m_tuser
);

    localparam logic [16:0] MaxPts = 17'(MAX_POINTS);

    // configuration
    logic [9:0]  step_reg;
    logic [15:0] maxdur_reg;

    // plan state
    logic signed [15:0] plan_start_reg [3];
    logic signed [16:0] plan_delta_reg [3];
    logic [15:0]        plan_dur_reg;
    logic [6:0]         plan_pts_reg;

    // working registers
    logic               act_reg;
    logic [15:0]        t_reg;
    logic               clamp_reg;
    logic [16:0]        s_reg;
    logic [16:0]        s2_reg;
    logic [16:0]        b_reg;
    logic signed [35:0] prod_reg;
    logic [15:0]        pos_reg [3];

    // output register
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic        m_tuser_reg;

    // input fields
    logic [15:0] in_start [3];
    logic [15:0] in_end   [3];
    logic [15:0] in_dur;
    logic [6:0]  in_idx;

    logic [9:0]         eff_step;
    logic [15:0]        dur_clamped;
    logic [6:0]         idx_sel;
    logic               idx_over;
    logic [16:0]        t_full;
    logic [31:0]        div_dividend;
    logic [15:0]        div_divisor;
    logic [31:0]        div_quot;
    logic               div_done;
    logic [16:0]        pts_full;
    logic [16:0]        prod_hi;
    logic signed [19:0] b_wide;
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] rnd;
    logic signed [17:0] offset;
    logic signed [17:0] pos_sum;
    logic [15:0]        pos_sat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_start[i] = s_tdata[16*i +: 16];
            in_end[i]   = s_tdata[48 + 16*i +: 16];
        end
        in_dur = s_tdata[111:96];
        in_idx = s_tdata[118:112];
    end

    // a zero step period acts as one
    assign eff_step    = (step_reg == '0) ? 10'd1 : step_reg;
    assign dur_clamped = (in_dur > maxdur_reg) ? maxdur_reg : in_dur;
    assign idx_over    = in_idx >= plan_pts_reg;
    assign idx_sel     = idx_over ? plan_pts_reg - 7'd1 : in_idx;
    assign t_full      = 17'(eff_step * idx_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= STEP_PERIOD_RST;
            maxdur_reg <= MAX_DURATION_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_STEP_PERIOD:  step_reg   <= cfg_wdata[9:0];
                REG_MAX_DURATION: maxdur_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // plan: duration / step for the point count; sample: (t << 16) / duration
    assign div_dividend = (act_reg == ACT_PLAN) ? {16'd0, plan_dur_reg} : {t_reg, 16'd0};
    assign div_divisor  = (act_reg == ACT_PLAN) ? {6'd0, eff_step} : plan_dur_reg;

    cts_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (cmd_i.div_start),
        .dividend_i (div_dividend),
        .divisor_i  (div_divisor),
        .quot_o     (div_quot),
        .done_o     (div_done)
    );

    assign pts_full = {1'b0, div_quot[15:0]} + 17'd1;
    assign prod_hi  = prod_reg[32:16];

    // shared multiplier operands
    always_comb begin
        mul_a = $signed({1'b0, s_reg});
        mul_b = $signed({1'b0, s_reg});
        if (cmd_i.mul_s3) begin
            mul_a = $signed({1'b0, prod_hi});
        end else if (cmd_i.mul_ax) begin
            mul_a = $signed({plan_delta_reg[cmd_i.ax_sel][16], plan_delta_reg[cmd_i.ax_sel]});
            mul_b = $signed({1'b0, b_reg});
        end
    end

    // 3 s^2 - 2 s^3
    assign b_wide = $signed({3'd0, s2_reg}) + $signed({2'd0, s2_reg, 1'b0})
                  - $signed({2'd0, prod_hi, 1'b0});

    // round half up, floor shift, add start, saturate
    assign rnd     = prod_reg + 36'sd32768;
    assign offset  = rnd[33:16];
    assign pos_sum = $signed({{2{plan_start_reg[cmd_i.st_sel][15]}},
                              plan_start_reg[cmd_i.st_sel]}) + offset;
    always_comb begin
        if (pos_sum > 18'sd32767) begin
            pos_sat = 16'h7FFF;
        end else if (pos_sum < -18'sd32768) begin
            pos_sat = 16'h8000;
        end else begin
            pos_sat = pos_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                plan_start_reg[i] <= '0;
                plan_delta_reg[i] <= '0;
            end
            plan_dur_reg <= '0;
            plan_pts_reg <= 7'd1;
        end else begin
            if (cmd_i.load && s_tuser[0] == ACT_PLAN) begin
                for (int i = 0; i < 3; i++) begin
                    plan_start_reg[i] <= $signed(in_start[i]);
                    plan_delta_reg[i] <= $signed({in_end[i][15], in_end[i]})
                                       - $signed({in_start[i][15], in_start[i]});
                end
                plan_dur_reg <= dur_clamped;
            end
            if (cmd_i.prep && act_reg == ACT_PLAN) begin
                plan_pts_reg <= (pts_full > MaxPts) ? MaxPts[6:0] : pts_full[6:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            act_reg <= s_tuser[0];
            if (s_tuser[0] == ACT_PLAN) begin
                t_reg     <= '0;
                clamp_reg <= 1'b0;
            end else begin
                t_reg     <= (t_full > {1'b0, plan_dur_reg}) ? plan_dur_reg : t_full[15:0];
                clamp_reg <= idx_over;
            end
        end
        if (cmd_i.prep) begin
            // zero duration gives s = 1, hence the end pose
            if (plan_dur_reg == '0) begin
                s_reg <= S_ONE;
            end else if (act_reg == ACT_PLAN) begin
                s_reg <= '0;
            end else begin
                s_reg <= div_quot[16:0];
            end
        end
        if (cmd_i.mul_ss || cmd_i.mul_s3 || cmd_i.mul_ax) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd_i.mul_s3) begin
            s2_reg <= prod_hi;
        end
        if (cmd_i.blend) begin
            if (b_wide < 20'sd0) begin
                b_reg <= '0;
            end else if (b_wide > 20'sd65536) begin
                b_reg <= S_ONE;
            end else begin
                b_reg <= b_wide[16:0];
            end
        end
        if (cmd_i.store_ax) begin
            pos_reg[cmd_i.st_sel] <= pos_sat;
        end
        if (cmd_i.out_load) begin
            m_tdata_reg <= {1'b0, plan_pts_reg, pos_reg[2], pos_reg[1], pos_reg[0]};
            m_tuser_reg <= clamp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd_i.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign sts_o.div_done = div_done;
    assign sts_o.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> design/cts_ctrl.sv
module cts_ctrl import cts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output cmd_t cmd_o,
    input  sts_t sts_i
);

    st_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                cmd_o.div_start = 1'b1;
                state_next      = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts_i.div_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd_o.prep = 1'b1;
                state_next = ST_MUL_SS;
            end
            ST_MUL_SS: begin
                cmd_o.mul_ss = 1'b1;
                state_next   = ST_MUL_S3;
            end
            ST_MUL_S3: begin
                cmd_o.mul_s3 = 1'b1;
                state_next   = ST_BLEND;
            end
            ST_BLEND: begin
                cmd_o.blend = 1'b1;
                state_next  = ST_AX0;
            end
            ST_AX0: begin
                cmd_o.mul_ax = 1'b1;
                cmd_o.ax_sel = 2'd0;
                state_next   = ST_AX1;
            end
            ST_AX1: begin
                cmd_o.mul_ax   = 1'b1;
                cmd_o.ax_sel   = 2'd1;
                cmd_o.store_ax = 1'b1;
                cmd_o.st_sel   = 2'd0;
                state_next     = ST_AX2;
            end
            ST_AX2: begin
                cmd_o.mul_ax   = 1'b1;
                cmd_o.ax_sel   = 2'd2;
                cmd_o.store_ax = 1'b1;
                cmd_o.st_sel   = 2'd1;
                state_next     = ST_STORE2;
            end
            ST_STORE2: begin
                cmd_o.store_ax = 1'b1;
                cmd_o.st_sel   = 2'd2;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (sts_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/cubic_trajectory_sampler.sv
// Three-axis cubic trajectory sampler with zero velocity at both ends. A plan
// item (s_tuser 0) stores the start pose, end - start and the duration clamped
// to max_duration_ms, works out the point count floor(duration / step) + 1
// capped at MAX_POINTS, and answers with point 0. A sample item (s_tuser 1)
// answers with start + delta * (3s^2 - 2s^3), s = t / duration, where
// t = step_period_ms * index clamped to the duration; an index at or past the
// point count gives the last point and raises m_tuser. Zero duration gives the
// end pose. Items are worked one at a time, through the restoring divider and
// then five passes of the one shared 18x18 multiplier. The next item may be
// accepted while a result still waits in the output register.
module cubic_trajectory_sampler import cts_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: index 0 step_period_ms, index 1 max_duration_ms
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, duration_ms, step_index, pad
    input  logic [119:0] s_tdata,
    // action
    input  logic [0:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, point_count, pad
    output logic [55:0]  m_tdata,
    // index_clamped
    output logic [0:0]   m_tuser
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: divider, then s^2, s^3, blend, three axis products
    cts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd_o    (cmd),
        .sts_i    (sts)
    );

    // plan state, divider, shared multiplier and output register
    cts_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_i     (cmd),
        .sts_o     (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
